// ===== design/bawa_pkg.sv =====
// Shared types and constants for the bit-addressed word access unit.
`default_nettype none

package bawa_pkg;

  // Store geometry: bytes grouped into 32-bit rows, rows split over two banks.
  localparam int MEM_BYTES = 64;
  localparam int ROW_BYTES = 4;
  localparam int MEM_ROWS  = MEM_BYTES / ROW_BYTES;
  localparam int ROW_IDX_W = $clog2(MEM_ROWS);
  localparam int BANK_ROWS = MEM_ROWS / 2;
  localparam int BANK_AW   = $clog2(BANK_ROWS);
  localparam int ROW_W     = 8 * ROW_BYTES;

  // Bit address layout.
  localparam int ADDR_W    = 9;
  localparam int OFF_W     = 3;
  localparam int BASE_W    = ADDR_W - OFF_W;
  localparam int LAST_W    = BASE_W + 1;
  localparam int WORD_W    = 32;
  localparam int SHIFT_W   = $clog2(ROW_W);

  typedef logic [BANK_AW-1:0] bank_addr_t;
  typedef logic [ROW_W-1:0]   row_data_t;

  typedef enum logic [0:0] {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // Access request to one bank: one read and one write port.
  typedef struct packed {
    logic       rd_en;
    bank_addr_t rd_addr;
    logic       wr_en;
    bank_addr_t wr_addr;
    row_data_t  wr_data;
  } bank_req_t;

endpackage

`default_nettype wire

// ===== design/bawa_bank.sv =====
// One bank of 32-bit rows with registered read, row valid bits and same-cycle forwarding.
`default_nettype none

module bawa_bank (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bawa_pkg::bank_req_t req,
  output logic [bawa_pkg::ROW_W-1:0] rd_data
);

  logic [bawa_pkg::ROW_W-1:0]     mem_r [bawa_pkg::BANK_ROWS];
  logic [bawa_pkg::BANK_ROWS-1:0] valid_r;
  logic [bawa_pkg::ROW_W-1:0]     rd_data_r;
  logic                           rd_vld_r;
  logic                           fwd_hit_r;
  logic [bawa_pkg::ROW_W-1:0]     fwd_data_r;

  // Storage array: write port and registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r  <= mem_r[req.rd_addr];
      fwd_data_r <= req.wr_data;
    end
  end

  // Row valid bits and read-side control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r  <= valid_r[req.rd_addr];
        fwd_hit_r <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
    end
  end

  // A row never written since reset reads as zero.
  always_comb begin
    if (fwd_hit_r) begin
      rd_data = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_data = rd_data_r;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/bit_addressed_word_access_unit.sv =====
// Top level of the bit-addressed word access unit.
//
// Input channel (in_valid / in_stall): one word access per item. in_command
// selects a read or a write of a 32-bit word whose least significant bit is
// at in_bit_address; in_write_value is the word stored by a write.
// Result channel (out_valid / out_stall): one result per item. out_read_value
// holds the word read, zero for a write or a range error; out_range_error is
// set when the access would touch a byte beyond the 64-byte store, in which
// case nothing is written.
// An item is held in the access stage, then presented from the result
// register. Throughput: one item per cycle while out_stall is low. The store
// is two banks of 32-bit rows with registered reads; an item reads both rows
// it touches at acceptance, a write stores them back as it completes, and a
// read of a row written in the same cycle is forwarded inside the bank.
// Reset (rst_n, synchronous, active low) clears all rows to zero at once
// through per-row valid bits, so items are taken right after reset.
// When the receiver stalls, the result register holds; the item in flight
// waits behind it and no further item is accepted until the result moves.
`default_nettype none

module bit_addressed_word_access_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [8:0]  in_bit_address,
  input  wire logic [31:0] in_write_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_value,
  output logic             out_range_error
);

  logic                                 in_accept;
  logic                                 complete;
  logic                                 stage_v_r;
  bawa_pkg::cmd_t                       st_cmd_r;
  logic [bawa_pkg::ADDR_W-1:0]          st_addr_r;
  logic [bawa_pkg::WORD_W-1:0]          st_value_r;
  logic                                 st_err_r;
  logic                                 in_err;
  logic [bawa_pkg::LAST_W-1:0]          in_last;
  logic [bawa_pkg::ROW_IDX_W-1:0]       in_row;
  logic [bawa_pkg::ROW_IDX_W-1:0]       st_row;
  bawa_pkg::bank_req_t                  even_req;
  bawa_pkg::bank_req_t                  odd_req;
  logic [bawa_pkg::ROW_W-1:0]           even_data;
  logic [bawa_pkg::ROW_W-1:0]           odd_data;
  logic [2*bawa_pkg::ROW_W-1:0]         window;
  logic [2*bawa_pkg::ROW_W-1:0]         wmask;
  logic [2*bawa_pkg::ROW_W-1:0]         new_window;
  logic [bawa_pkg::SHIFT_W-1:0]         shamt;
  logic                                 st_lo_odd;
  logic                                 hi_touch;
  logic                                 wr_go;
  logic [bawa_pkg::WORD_W-1:0]          rd_word;
  logic                                 out_valid_r;
  logic [bawa_pkg::WORD_W-1:0]          out_read_value_r;
  logic                                 out_range_error_r;

  // Handshake: the stage drains into the output register when it is free.
  assign complete  = stage_v_r && (!out_valid_r || !out_stall);
  assign in_stall  = stage_v_r && !complete;
  assign in_accept = in_valid && !in_stall;

  // Range check on the last byte the access touches.
  assign in_last = {1'b0, in_bit_address[bawa_pkg::ADDR_W-1:bawa_pkg::OFF_W]}
                 + ((in_bit_address[bawa_pkg::OFF_W-1:0] != '0) ?
                    bawa_pkg::LAST_W'(4) : bawa_pkg::LAST_W'(3));
  assign in_err  = (in_last >= bawa_pkg::LAST_W'(bawa_pkg::MEM_BYTES));

  // Row index of the lower row; the access may spill into the next row.
  assign in_row = in_bit_address[bawa_pkg::ADDR_W-1:bawa_pkg::SHIFT_W];
  assign st_row = st_addr_r[bawa_pkg::ADDR_W-1:bawa_pkg::SHIFT_W];
  assign st_lo_odd = st_row[0];
  assign shamt     = st_addr_r[bawa_pkg::SHIFT_W-1:0];
  assign hi_touch  = (shamt != '0);
  assign wr_go     = complete && (st_cmd_r == bawa_pkg::CMD_WRITE) && !st_err_r;

  // Bank requests: reads at acceptance, write-back when the stage completes.
  always_comb begin
    even_req.rd_en   = in_accept;
    even_req.rd_addr = in_row[0]
                     ? (in_row[bawa_pkg::ROW_IDX_W-1:1] + bawa_pkg::BANK_AW'(1))
                     : in_row[bawa_pkg::ROW_IDX_W-1:1];
    odd_req.rd_en    = in_accept;
    odd_req.rd_addr  = in_row[bawa_pkg::ROW_IDX_W-1:1];

    even_req.wr_en   = wr_go && (!st_lo_odd || hi_touch);
    even_req.wr_addr = st_lo_odd
                     ? (st_row[bawa_pkg::ROW_IDX_W-1:1] + bawa_pkg::BANK_AW'(1))
                     : st_row[bawa_pkg::ROW_IDX_W-1:1];
    even_req.wr_data = st_lo_odd ? new_window[2*bawa_pkg::ROW_W-1:bawa_pkg::ROW_W]
                                 : new_window[bawa_pkg::ROW_W-1:0];
    odd_req.wr_en    = wr_go && (st_lo_odd || hi_touch);
    odd_req.wr_addr  = st_row[bawa_pkg::ROW_IDX_W-1:1];
    odd_req.wr_data  = st_lo_odd ? new_window[bawa_pkg::ROW_W-1:0]
                                 : new_window[2*bawa_pkg::ROW_W-1:bawa_pkg::ROW_W];
  end

  bawa_bank u_even_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (even_req),
    .rd_data (even_data)
  );

  bawa_bank u_odd_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (odd_req),
    .rd_data (odd_data)
  );

  // Two-row window, extract and merge of the word at the bit offset.
  assign window     = st_lo_odd ? {even_data, odd_data} : {odd_data, even_data};
  assign rd_word    = bawa_pkg::WORD_W'(window >> shamt);
  assign wmask      = (2*bawa_pkg::ROW_W)'({bawa_pkg::WORD_W{1'b1}}) << shamt;
  assign new_window = (window & ~wmask)
                    | (((2*bawa_pkg::ROW_W)'(st_value_r) << shamt) & wmask);

  // Access stage: control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_accept) begin
      stage_v_r <= 1'b1;
    end else if (complete) begin
      stage_v_r <= 1'b0;
    end
  end

  // Access stage: payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      st_cmd_r   <= bawa_pkg::cmd_t'(in_command);
      st_addr_r  <= in_bit_address;
      st_value_r <= in_write_value;
      st_err_r   <= in_err;
    end
  end

  // Output register: control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (complete) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (complete) begin
      out_range_error_r <= st_err_r;
      out_read_value_r  <= (st_cmd_r == bawa_pkg::CMD_READ && !st_err_r) ? rd_word : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_range_error = out_range_error_r;

  // An out-of-range access never writes either bank.
  assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r && st_err_r) |-> !(even_req.wr_en || odd_req.wr_en))
    else $error("write issued for an out-of-range access");

  // A new word is only taken when the stage is empty or draining.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (!stage_v_r || complete))
    else $error("word accepted over an occupied stage");

  // A completed write returns a zero read value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (complete && st_cmd_r == bawa_pkg::CMD_WRITE) |=> (out_read_value == '0))
    else $error("write returned a nonzero read value");

  // A range error always reads zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_read_value == '0))
    else $error("range error with nonzero read value");

endmodule

`default_nettype wire
